### rtl/nepm_pkg.sv
// ----------------------------------------------------------------------------
// nepm_pkg
// Shared types and constants for the nearest eta/phi match unit.
// ----------------------------------------------------------------------------
package nepm_pkg;

  localparam int ETA_W    = 14;
  localparam int PHI_W    = 13;
  localparam int EN_W     = 16;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 12;
  localparam int DIST_W   = 29;
  localparam int SQ_E_W   = 28;  // (2^14 - 1)^2 < 2^28
  localparam int SQ_P_W   = 24;  // wrapped dphi is within +/-pi, 3217^2 < 2^24

  localparam int MAX_DEPOSITS_DEF = 4096;

  // pi and 2*pi in units of 1/1024, sized for the raw phi difference
  localparam logic signed [PHI_W:0] PI_FIX     = 14'sd3217;
  localparam logic signed [PHI_W:0] TWO_PI_FIX = 14'sd6434;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED  = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_MATCH    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // result of the shared distance unit
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dsq;
  } dist_res_t;

endpackage

### rtl/nepm_ram.sv
// ----------------------------------------------------------------------------
// nepm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nepm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/nepm_dist_unit.sv
// ----------------------------------------------------------------------------
// nepm_dist_unit
// Shared squared-distance pipeline: deta^2 + wrapped dphi^2, three stages.
// ----------------------------------------------------------------------------
module nepm_dist_unit
  import nepm_pkg::*;
#(
  parameter int TAG_W = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [ETA_W-1:0] eta_a,
  input  logic signed [PHI_W-1:0] phi_a,
  input  logic signed [ETA_W-1:0] eta_b,
  input  logic signed [PHI_W-1:0] phi_b,
  input  logic [TAG_W-1:0]        in_tag,
  output dist_res_t               res,
  output logic [TAG_W-1:0]        res_tag
);

  logic signed [ETA_W:0]     de_w;
  logic signed [PHI_W:0]     dp_raw;
  logic signed [PHI_W:0]     dp_w;
  logic signed [2*ETA_W+1:0] prod_e;
  logic signed [2*PHI_W-1:0] prod_p;

  logic                    v1_r, v2_r, v3_r;
  logic [TAG_W-1:0]        t1_r, t2_r, t3_r;
  logic signed [ETA_W:0]   de_r;
  logic signed [PHI_W-1:0] dp_r;
  logic [SQ_E_W-1:0]       sq_e_r;
  logic [SQ_P_W-1:0]       sq_p_r;
  logic [DIST_W-1:0]       dist_r;

  always_comb begin
    de_w   = $signed({eta_a[ETA_W-1], eta_a}) - $signed({eta_b[ETA_W-1], eta_b});
    dp_raw = $signed({phi_a[PHI_W-1], phi_a}) - $signed({phi_b[PHI_W-1], phi_b});
    // one 2*pi correction suffices for any 13-bit phi pair
    if (dp_raw > PI_FIX) begin
      dp_w = dp_raw - TWO_PI_FIX;
    end else if (dp_raw < -PI_FIX) begin
      dp_w = dp_raw + TWO_PI_FIX;
    end else begin
      dp_w = dp_raw;
    end
  end

  assign prod_e = de_r * de_r;
  assign prod_p = dp_r * dp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    t1_r   <= in_tag;
    de_r   <= de_w;
    dp_r   <= dp_w[PHI_W-1:0];
    t2_r   <= t1_r;
    sq_e_r <= prod_e[SQ_E_W-1:0];
    sq_p_r <= prod_p[SQ_P_W-1:0];
    t3_r   <= t2_r;
    dist_r <= {1'b0, sq_e_r} + {{(DIST_W-SQ_P_W){1'b0}}, sq_p_r};
  end

  assign res.valid = v3_r;
  assign res.dsq   = dist_r;
  assign res_tag   = t3_r;

endmodule

### rtl/nearest_eta_phi_match_unit.sv
// ----------------------------------------------------------------------------
// nearest_eta_phi_match_unit
// Deposit list with nearest-neighbour (eta, phi) search for a track direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): mode 0 clears the list, mode 1 appends a deposit,
//   mode 2 queries the nearest stored deposit to (in_item_eta, in_item_phi).
//   Mode 3 is taken and ignored. Result channel (out_*): one transfer per
//   clear, append or query.
//   Clear and append need no scan; the result is registered the cycle after
//   the input transfer. A query with N stored entries walks the deposit RAM
//   one entry per cycle through a single shared distance pipeline (RAM read
//   plus three arithmetic stages); its result is registered once all N
//   entries are compared. in_stall is high during a scan.
//   An item is taken only when the output register is empty or draining, so
//   a stalled receiver holds the result and in turn stalls the input.
//   Reset empties the list (count to zero) and drops any pending result; the
//   deposit RAM is not cleared since only written entries are ever read.
// ----------------------------------------------------------------------------
module nearest_eta_phi_match_unit
  import nepm_pkg::*;
#(
  parameter int MAX_DEPOSITS = MAX_DEPOSITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_mode,
  input  logic signed [ETA_W-1:0] in_item_eta,
  input  logic signed [PHI_W-1:0] in_item_phi,
  input  logic [EN_W-1:0]         in_deposit_energy,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic [IDX_W-1:0]        out_match_index,
  output logic [EN_W-1:0]         out_match_energy,
  output logic [DIST_W-1:0]       out_match_dist_sq
);

  localparam int ADDR_W = (MAX_DEPOSITS > 1) ? $clog2(MAX_DEPOSITS) : 1;
  localparam int CNT_W  = $clog2(MAX_DEPOSITS + 1);
  localparam int WORD_W = ETA_W + PHI_W + EN_W;
  localparam int TAG_W  = ADDR_W + EN_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEPOSITS);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        iss_r, iss_nxt;
  logic [CNT_W-1:0]        cmp_r, cmp_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic signed [ETA_W-1:0] q_eta_r, q_eta_nxt;
  logic signed [PHI_W-1:0] q_phi_r, q_phi_nxt;
  logic [DIST_W-1:0]       best_dist_r, best_dist_nxt;
  logic [ADDR_W-1:0]       best_idx_r, best_idx_nxt;
  logic [EN_W-1:0]         best_en_r, best_en_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic [EN_W-1:0]         out_en_r, out_en_nxt;
  logic [DIST_W-1:0]       out_dist_r, out_dist_nxt;

  logic                    in_xfer;
  logic                    out_free;
  logic                    ram_we;
  logic [WORD_W-1:0]       ram_wdata;
  logic [WORD_W-1:0]       ram_rdata;
  logic signed [ETA_W-1:0] rd_eta;
  logic signed [PHI_W-1:0] rd_phi;
  logic [EN_W-1:0]         rd_en;
  dist_res_t               dres;
  logic [TAG_W-1:0]        dres_tag;
  logic [ADDR_W-1:0]       cand_idx;
  logic [EN_W-1:0]         cand_en;
  logic                    better;
  logic [31:0]             idx_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign ram_we    = in_xfer && (in_mode == MODE_APPEND) && (cnt_r < CNT_MAX);
  assign ram_wdata = {in_item_eta, in_item_phi, in_deposit_energy};

  nepm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_DEPOSITS),
    .AW   (ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(ram_wdata),
    .raddr(iss_r[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_eta = ram_rdata[WORD_W-1 -: ETA_W];
  assign rd_phi = ram_rdata[EN_W +: PHI_W];
  assign rd_en  = ram_rdata[EN_W-1:0];

  nepm_dist_unit #(
    .TAG_W(TAG_W)
  ) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (rd_vld_r),
    .eta_a  (q_eta_r),
    .phi_a  (q_phi_r),
    .eta_b  (rd_eta),
    .phi_b  (rd_phi),
    .in_tag ({rd_idx_r, rd_en}),
    .res    (dres),
    .res_tag(dres_tag)
  );

  assign cand_idx = dres_tag[TAG_W-1 -: ADDR_W];
  assign cand_en  = dres_tag[EN_W-1:0];
  // strict compare keeps the earliest entry on ties
  assign better   = (cmp_r == '0) || (dres.dsq < best_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    iss_r        <= iss_nxt;
    cmp_r        <= cmp_nxt;
    rd_idx_r     <= rd_idx_nxt;
    q_eta_r      <= q_eta_nxt;
    q_phi_r      <= q_phi_nxt;
    best_dist_r  <= best_dist_nxt;
    best_idx_r   <= best_idx_nxt;
    best_en_r    <= best_en_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_en_r     <= out_en_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    cmp_nxt        = cmp_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = iss_r[ADDR_W-1:0];
    q_eta_nxt      = q_eta_r;
    q_phi_nxt      = q_phi_r;
    best_dist_nxt  = best_dist_r;
    best_idx_nxt   = best_idx_r;
    best_en_nxt    = best_en_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_en_nxt     = out_en_r;
    out_dist_nxt   = out_dist_r;
    idx_ext        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          idx_ext = 32'(cnt_r);
          case (in_mode)
            MODE_CLEAR: begin
              cnt_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_CLEARED;
              out_idx_nxt    = '0;
              out_en_nxt     = '0;
              out_dist_nxt   = '0;
            end
            MODE_APPEND: begin
              out_valid_nxt = 1'b1;
              out_en_nxt    = '0;
              out_dist_nxt  = '0;
              if (cnt_r < CNT_MAX) begin
                cnt_nxt        = cnt_r + CNT_W'(1);
                out_status_nxt = ST_APPENDED;
                out_idx_nxt    = idx_ext[IDX_W-1:0];
              end else begin
                out_status_nxt = ST_FULL;
                out_idx_nxt    = '0;
              end
            end
            MODE_QUERY: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_idx_nxt    = '0;
                out_en_nxt     = '0;
                out_dist_nxt   = '0;
              end else begin
                q_eta_nxt = in_item_eta;
                q_phi_nxt = in_item_phi;
                iss_nxt   = '0;
                cmp_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue one RAM read per cycle
        if (iss_r < cnt_r) begin
          rd_vld_nxt = 1'b1;
          iss_nxt    = iss_r + CNT_W'(1);
        end
        if (dres.valid) begin
          cmp_nxt = cmp_r + CNT_W'(1);
          if (better) begin
            best_dist_nxt = dres.dsq;
            best_idx_nxt  = cand_idx;
            best_en_nxt   = cand_en;
          end
          if (cmp_nxt == cnt_r) begin
            idx_ext        = 32'(best_idx_nxt);
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MATCH;
            out_idx_nxt    = idx_ext[IDX_W-1:0];
            out_en_nxt     = best_en_nxt;
            out_dist_nxt   = best_dist_nxt;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_match_index   = out_idx_r;
  assign out_match_energy  = out_en_r;
  assign out_match_dist_sq = out_dist_r;

  // output slot stays empty for the whole scan
  a_scan_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !out_valid_r)
    else $error("result pending during scan");

  // list never grows past its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("entry count over capacity");

  // distance results only arrive while scanning
  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dres.valid |-> (state_r == S_SCAN))
    else $error("distance result outside scan");

  // a scan never lasts into an accepted input
  a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_xfer)
    else $error("input accepted during scan");

endmodule

### tb/sv/tb_nearest_eta_phi_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_eta_phi_match_unit
// Directed and random test of the deposit list and its nearest eta/phi search.
// Every accepted item is run through a behavioral copy of the list, and each
// output transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_nearest_eta_phi_match_unit;
  import nepm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;

  // idle profiles: sender/receiver idle 34/47, then 47/34, then none
  localparam int PACE_MIXED   = 0;
  localparam int PACE_SWAPPED = 1;
  localparam int PACE_FULL    = 2;

  typedef struct {
    logic [1:0]              mode;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    logic [EN_W-1:0]         energy;
    int                      pace;
    bit                      drain;    // wait for all results before offering
    bit                      hold_rx;  // start a long receiver hold-off
  } track_item_t;

  typedef struct {
    status_t           status;
    logic [IDX_W-1:0]  index;
    logic [EN_W-1:0]   energy;
    logic [DIST_W-1:0] dsq;
  } match_res_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_mode = MODE_CLEAR;
  logic signed [ETA_W-1:0] in_item_eta = '0;
  logic signed [PHI_W-1:0] in_item_phi = '0;
  logic [EN_W-1:0]         in_deposit_energy = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [IDX_W-1:0]        out_match_index;
  logic [EN_W-1:0]         out_match_energy;
  logic [DIST_W-1:0]       out_match_dist_sq;

  track_item_t pending_items[$];
  match_res_t  expected_matches[$];
  int          recent_eta[$];
  int          recent_phi[$];

  // behavioral copy of the deposit list
  int dep_eta[0:MAX_DEPOSITS_DEF-1];
  int dep_phi[0:MAX_DEPOSITS_DEF-1];
  int dep_energy[0:MAX_DEPOSITS_DEF-1];
  int dep_count = 0;

  int pace = PACE_MIXED;
  bit rx_hold_req = 1'b0;
  int hold_left = 0;
  int n_bad = 0;

  nearest_eta_phi_match_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_item_eta       (in_item_eta),
    .in_item_phi       (in_item_phi),
    .in_deposit_energy (in_deposit_energy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_match_index   (out_match_index),
    .out_match_energy  (out_match_energy),
    .out_match_dist_sq (out_match_dist_sq)
  );

  always #4 clk = ~clk;

  task automatic predict_match(input logic [1:0] mode, input logic signed [ETA_W-1:0] eta,
                               input logic signed [PHI_W-1:0] phi,
                               input logic [EN_W-1:0] energy);
    match_res_t  r;
    int          de, dp;
    int unsigned d;
    r.status = ST_CLEARED;
    r.index  = '0;
    r.energy = '0;
    r.dsq    = '0;
    case (mode)
      MODE_CLEAR: dep_count = 0;
      MODE_APPEND: begin
        if (dep_count >= MAX_DEPOSITS_DEF) begin
          r.status = ST_FULL;
        end else begin
          dep_eta[dep_count]    = int'(eta);
          dep_phi[dep_count]    = int'(phi);
          dep_energy[dep_count] = int'(energy);
          r.index  = IDX_W'(dep_count);
          r.status = ST_APPENDED;
          dep_count++;
        end
      end
      MODE_QUERY: begin
        if (dep_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_MATCH;
          for (int i = 0; i < dep_count; i++) begin
            de = int'(eta) - dep_eta[i];
            dp = int'(phi) - dep_phi[i];
            // one 2*pi correction brings any 13-bit difference into range
            if (dp > int'(PI_FIX))
              dp -= int'(TWO_PI_FIX);
            else if (dp < -int'(PI_FIX))
              dp += int'(TWO_PI_FIX);
            d = de * de + dp * dp;
            // strict compare: earliest entry wins ties
            if (i == 0 || d < r.dsq) begin
              r.dsq   = DIST_W'(d);
              r.index = IDX_W'(i);
            end
          end
          r.energy = EN_W'(dep_energy[r.index]);
        end
      end
      default: return;
    endcase
    expected_matches.push_back(r);
  endtask

  task automatic push_item(input logic [1:0] mode, input int eta, input int phi,
                           input int energy, input int pace_sel, input bit drain,
                           input bit hold_rx);
    track_item_t it;
    it.mode    = mode;
    it.eta     = ETA_W'(eta);
    it.phi     = PHI_W'(phi);
    it.energy  = EN_W'(energy);
    it.pace    = pace_sel;
    it.drain   = drain;
    it.hold_rx = hold_rx;
    pending_items.push_back(it);
  endtask

  // mostly appends and queries, some near earlier deposits; clears keep lists short
  task automatic add_random(input int count, input int pace_sel, input int drain_at);
    int n, pick, k, eta, phi, en;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      eta  = int'($urandom_range(16383)) - 8192;
      phi  = $urandom_range(1) ? int'($urandom_range(8191)) - 4096
                               : int'($urandom_range(6434)) - 3217;
      en   = int'($urandom_range(65535));
      if (pick < 6) begin
        push_item(MODE_UNUSED, eta, phi, en, pace_sel, 1'b0, 1'b0);
      end else begin
        if (pick < 14) begin
          push_item(MODE_CLEAR, eta, phi, en, pace_sel, n == drain_at, 1'b0);
          recent_eta.delete();
          recent_phi.delete();
        end else if (pick < 58) begin
          if (recent_eta.size() != 0 && $urandom_range(3) == 0) begin
            k   = $urandom_range(recent_eta.size() - 1);
            eta = recent_eta[k];
            phi = recent_phi[k];
          end
          push_item(MODE_APPEND, eta, phi, en, pace_sel, n == drain_at, 1'b0);
          recent_eta.push_back(eta);
          recent_phi.push_back(phi);
        end else begin
          if (recent_eta.size() != 0 && $urandom_range(1) == 0) begin
            k   = $urandom_range(recent_eta.size() - 1);
            eta = recent_eta[k] + int'($urandom_range(8)) - 4;
            phi = recent_phi[k] + int'($urandom_range(8)) - 4;
          end
          push_item(MODE_QUERY, eta, phi, en, pace_sel, n == drain_at, 1'b0);
        end
        n++;
      end
    end
  endtask

  // input side: a transfer is predicted at the edge where it is taken
  always @(posedge clk) begin : drive_items
    track_item_t nxt;
    bit          offer;
    int          tx_idle;
    offer = 1'b0;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      rx_hold_req <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_match(in_mode, in_item_eta, in_item_phi, in_deposit_energy);
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() != 0) begin
          tx_idle = (pending_items[0].pace == PACE_MIXED)   ? 34 :
                    (pending_items[0].pace == PACE_SWAPPED) ? 47 : 0;
          if (!(pending_items[0].drain && expected_matches.size() != 0) &&
              $urandom_range(99) >= tx_idle) begin
            nxt   = pending_items.pop_front();
            offer = 1'b1;
            in_mode           <= nxt.mode;
            in_item_eta       <= nxt.eta;
            in_item_phi       <= nxt.phi;
            in_deposit_energy <= nxt.energy;
            pace              <= nxt.pace;
          end
        end
        in_valid <= offer;
      end
      rx_hold_req <= offer && nxt.hold_rx;
    end
  end

  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (rx_hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= $urandom_range(99) < ((pace == PACE_MIXED)   ? 47 :
                                         (pace == PACE_SWAPPED) ? 34 : 0);
    end
  end

  always @(posedge clk) begin : check_results
    match_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected transfer: status %0d index %0d energy %0d dist %0d",
                   out_status, out_match_index, out_match_energy, out_match_dist_sq);
      end else begin
        want = expected_matches.pop_front();
        if (out_status !== want.status || out_match_index !== want.index ||
            out_match_energy !== want.energy || out_match_dist_sq !== want.dsq) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp status %0d index %0d energy %0d dist %0d, got %0d %0d %0d %0d",
                     want.status, want.index, want.energy, want.dsq, out_status,
                     out_match_index, out_match_energy, out_match_dist_sq);
        end
      end
    end
  end

  initial begin
    // directed: empty list, field extremes, ties, phi wrap, ignored mode
    push_item(MODE_QUERY,   0,     0,     0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_CLEAR,   0,     0,     0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   5,     -5,    0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  -8192, -4096, 0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  8191,  4095,  65535,  PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  0,     0,     'h5A5A, PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  0,     0,     'hA5A5, PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  100,   -3217, 'h1234, PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   0,     0,     0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   -8192, -4096, 0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   8191,  4095,  0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   100,   3217,  0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   8191,  -4096, 0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_UNUSED,  -1,    -1,    65535,  PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  -500,  3000,  65535,  PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   -500,  -3000, 0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   20,    3217,  0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_CLEAR,   0,     0,     0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   0,     0,     0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_APPEND,  1,     1,     1,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_QUERY,   -1,    -1,    0,      PACE_MIXED, 1'b0, 1'b0);
    push_item(MODE_CLEAR,   0,     0,     0,      PACE_MIXED, 1'b0, 1'b0);

    add_random(40, PACE_MIXED, 25);
    add_random(35, PACE_SWAPPED, -1);

    // short list at full rate, a random query and one at the field extremes
    push_item(MODE_CLEAR, 0, 0, 0, PACE_FULL, 1'b0, 1'b0);
    push_item(MODE_APPEND, 7, 7, 7, PACE_FULL, 1'b0, 1'b0);
    push_item(MODE_APPEND, -7, -7, 9, PACE_FULL, 1'b0, 1'b0);
    push_item(MODE_QUERY, int'($urandom_range(16383)) - 8192,
              int'($urandom_range(8191)) - 4096, 0, PACE_FULL, 1'b0, 1'b0);
    push_item(MODE_QUERY, 8191, 4095, 0, PACE_FULL, 1'b0, 1'b0);
    push_item(MODE_CLEAR, 0, 0, 0, PACE_FULL, 1'b0, 1'b0);
    recent_eta.delete();
    recent_phi.delete();

    // receiver holds off while the sender keeps offering random items
    push_item(MODE_APPEND, 300, -300, 42, PACE_FULL, 1'b0, 1'b1);
    recent_eta.push_back(300);
    recent_phi.push_back(-300);
    add_random(25, PACE_FULL, -1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (MAX_DEPOSITS_DEF + 8) @(posedge clk);
    if (n_bad == 0) begin
      $display("tb_nearest_eta_phi_match_unit: PASS");
    end else begin
      $display("tb_nearest_eta_phi_match_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_nearest_eta_phi_match_unit: FAIL");
    $finish;
  end

endmodule

### files.f
rtl/nepm_pkg.sv
rtl/nepm_ram.sv
rtl/nepm_dist_unit.sv
rtl/nearest_eta_phi_match_unit.sv
tb/sv/tb_nearest_eta_phi_match_unit.sv
